// ----- sv/fqs_pkg.sv -----
// ----------------------------------------------------------------------------
// fqs_pkg
// shared constants, types and helpers of the per-route fair queue shaper
// ----------------------------------------------------------------------------
package fqs_pkg;

  localparam int ROUTES          = 16;
  localparam int QUEUE_DEPTH     = 16;
  localparam int MAX_BURST       = 64;
  localparam int MIN_INTERVAL_MS = 25;
  localparam int MS_PER_SECOND   = 1000;
  localparam int FAST_RATE       = MS_PER_SECOND / MIN_INTERVAL_MS;

  localparam int RW    = $clog2(ROUTES);
  localparam int QW    = $clog2(QUEUE_DEPTH);
  localparam int CW    = $clog2(QUEUE_DEPTH + 1);
  localparam int AW    = RW + QW;
  localparam int SW    = $clog2(MAX_BURST + 1);
  localparam int TW    = 10;
  localparam int RATEW = 12;
  localparam int HWMW  = 5;
  localparam int PW    = 32;

  localparam logic [1:0] KIND_ACCEPT  = 2'd0;
  localparam logic [1:0] KIND_DROP    = 2'd1;
  localparam logic [1:0] KIND_DELIVER = 2'd2;

  localparam logic CMD_ADD  = 1'b0;
  localparam logic CMD_TICK = 1'b1;

  localparam logic CFG_RATE = 1'b0;
  localparam logic CFG_HWM  = 1'b1;

  typedef struct packed {
    logic          active;
    logic [TW-1:0] remaining;
    logic          first_pass;
    logic          last_empty;
  } timer_t;

  typedef struct packed {
    logic          found;
    logic [RW-1:0] idx;
  } find_t;

  // lowest set bit
  function automatic find_t find_first(input logic [ROUTES-1:0] vec);
    find_t f;
    f.found = |vec;
    f.idx   = '0;
    for (int i = ROUTES - 1; i >= 0; i--) begin
      if (vec[i]) begin
        f.idx = RW'(i);
      end
    end
    return f;
  endfunction

  // timer re-evaluation after an add, a batch or a rate write
  function automatic timer_t timer_setup(input timer_t cur, input logic rate_nz,
                                         input logic any, input logic [TW-1:0] interval);
    timer_t t;
    t = cur;
    if (rate_nz) begin
      if (any || !cur.last_empty) begin
        if (cur.active) begin
          if (!cur.first_pass) begin
            t.remaining = interval;
          end
        end else begin
          t.first_pass = 1'b1;
          t.active     = 1'b1;
          t.remaining  = '0;
        end
      end else begin
        t.last_empty = 1'b0;
        t.active     = 1'b0;
        t.remaining  = '0;
      end
    end else begin
      if (any) begin
        if (!cur.active) begin
          t.first_pass = 1'b1;
          t.active     = 1'b1;
        end
        t.remaining = '0;
      end else begin
        t.active    = 1'b0;
        t.remaining = '0;
      end
    end
    return t;
  endfunction

endpackage

// ----- sv/fqs_ram.sv -----
// ----------------------------------------------------------------------------
// fqs_ram
// generic single-port synchronous ram with registered read
// ----------------------------------------------------------------------------
module fqs_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[addr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ----- sv/fqs_rate.sv -----
// ----------------------------------------------------------------------------
// fqs_rate
// batch interval and batch size derived from the configured rate
// ----------------------------------------------------------------------------
module fqs_rate (
  input  logic [fqs_pkg::RATEW-1:0] rate,
  output logic [fqs_pkg::TW-1:0]    interval,
  output logic [fqs_pkg::SW-1:0]    size
);

  // 1000 / rate for the slow rates
  function automatic logic [fqs_pkg::TW-1:0] slow_interval(input logic [5:0] r);
    logic [fqs_pkg::TW-1:0] v;
    unique case (r)
      6'd1:  v = 10'd1000; 6'd2:  v = 10'd500; 6'd3:  v = 10'd333; 6'd4:  v = 10'd250;
      6'd5:  v = 10'd200;  6'd6:  v = 10'd166; 6'd7:  v = 10'd142; 6'd8:  v = 10'd125;
      6'd9:  v = 10'd111;  6'd10: v = 10'd100; 6'd11: v = 10'd90;  6'd12: v = 10'd83;
      6'd13: v = 10'd76;   6'd14: v = 10'd71;  6'd15: v = 10'd66;  6'd16: v = 10'd62;
      6'd17: v = 10'd58;   6'd18: v = 10'd55;  6'd19: v = 10'd52;  6'd20: v = 10'd50;
      6'd21: v = 10'd47;   6'd22: v = 10'd45;  6'd23: v = 10'd43;  6'd24: v = 10'd41;
      6'd25: v = 10'd40;   6'd26: v = 10'd38;  6'd27: v = 10'd37;  6'd28: v = 10'd35;
      6'd29: v = 10'd34;   6'd30: v = 10'd33;  6'd31: v = 10'd32;  6'd32: v = 10'd31;
      6'd33: v = 10'd30;   6'd34: v = 10'd29;  6'd35: v = 10'd28;  6'd36: v = 10'd27;
      6'd37: v = 10'd27;   6'd38: v = 10'd26;  6'd39: v = 10'd25;
      default: v = '0;
    endcase
    return v;
  endfunction

  logic                         fast;
  logic [fqs_pkg::RATEW:0]      biased;
  logic [fqs_pkg::RATEW+11:0]   prod;
  logic [7:0]                   q;
  logic [fqs_pkg::RATEW+1:0]    q40;
  logic [7:0]                   qc;

  assign fast   = rate >= fqs_pkg::RATEW'(fqs_pkg::FAST_RATE);
  // ceil(rate / 40) through a reciprocal that may land one high
  assign biased = {1'b0, rate} + (fqs_pkg::RATEW + 1)'(fqs_pkg::FAST_RATE - 1);
  assign prod   = (fqs_pkg::RATEW + 12)'(biased) * (fqs_pkg::RATEW + 12)'(1639);
  assign q      = prod[23:16];
  assign q40    = ((fqs_pkg::RATEW + 2)'(q) << 5) + ((fqs_pkg::RATEW + 2)'(q) << 3);
  assign qc     = (q40 > (fqs_pkg::RATEW + 2)'(biased)) ? q - 8'd1 : q;

  always_comb begin
    if (rate == '0) begin
      interval = '0;
      size     = fqs_pkg::SW'(fqs_pkg::MAX_BURST);
    end else if (fast) begin
      interval = fqs_pkg::TW'(fqs_pkg::MIN_INTERVAL_MS);
      size     = (qc > 8'(fqs_pkg::MAX_BURST)) ? fqs_pkg::SW'(fqs_pkg::MAX_BURST)
                                                : fqs_pkg::SW'(qc);
    end else begin
      interval = slow_interval(rate[5:0]);
      size     = fqs_pkg::SW'(1);
    end
  end

endmodule

// ----- sv/per_route_fair_queue_shaper_unit.sv -----
// ----------------------------------------------------------------------------
// per_route_fair_queue_shaper_unit
// per-route payload fifos in one ram, drained round-robin by a tick timer
// ----------------------------------------------------------------------------
// add result: registered, valid in the cycle after its request is taken
// throughput: adds and idle ticks take one request per cycle while the result
//   register drains; a firing tick sends each delivery through a ram read (S_RD)
//   and a result load (S_OUT), then closes the batch in S_FIN before new requests
// reset: synchronous, active low; queues empty, timer stopped, control registers zero
// ----------------------------------------------------------------------------
module per_route_fair_queue_shaper_unit (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          in_cmd,
  input  logic [fqs_pkg::RW-1:0]        in_route,
  input  logic [fqs_pkg::PW-1:0]        in_payload,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [1:0]                    out_kind,
  output logic [fqs_pkg::RW-1:0]        out_route,
  output logic [fqs_pkg::PW-1:0]        out_payload,
  output logic                          out_last,
  input  logic                          cfg_we,
  input  logic                          cfg_index,
  input  logic [fqs_pkg::RATEW-1:0]     cfg_wdata
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_SETUP = 3'd1;  // timer re-evaluation after a rate write
  localparam logic [2:0] S_RD    = 3'd2;  // pop one payload, read the ram
  localparam logic [2:0] S_OUT   = 3'd3;  // hand the read payload to the result register
  localparam logic [2:0] S_FIN   = 3'd4;  // close the batch, re-evaluate the timer

  logic [2:0]                  state_r, state_nxt;
  logic [fqs_pkg::RATEW-1:0]   rate_r, rate_nxt;
  logic [fqs_pkg::HWMW-1:0]    hwm_r, hwm_nxt;
  logic [fqs_pkg::QW-1:0]      head_r [fqs_pkg::ROUTES];
  logic [fqs_pkg::QW-1:0]      head_nxt [fqs_pkg::ROUTES];
  logic [fqs_pkg::CW-1:0]      cnt_r [fqs_pkg::ROUTES];
  logic [fqs_pkg::CW-1:0]      cnt_nxt [fqs_pkg::ROUTES];
  logic [fqs_pkg::RW-1:0]      resume_r, resume_nxt;
  logic                        resume_v_r, resume_v_nxt;
  fqs_pkg::timer_t             tmr_r, tmr_nxt;
  logic [fqs_pkg::RW-1:0]      it_r, it_nxt;
  logic                        itv_r, itv_nxt;
  logic [fqs_pkg::SW-1:0]      n_r, n_nxt;
  logic [fqs_pkg::SW-1:0]      limit_r, limit_nxt;
  logic                        done_r, done_nxt;
  logic [fqs_pkg::RW-1:0]      dl_route_r, dl_route_nxt;

  logic                        out_valid_r, out_valid_nxt;
  logic [1:0]                  out_kind_r, out_kind_nxt;
  logic [fqs_pkg::RW-1:0]      out_route_r, out_route_nxt;
  logic [fqs_pkg::PW-1:0]      out_payload_r, out_payload_nxt;
  logic                        out_last_r, out_last_nxt;

  logic [fqs_pkg::TW-1:0]      interval;
  logic [fqs_pkg::SW-1:0]      size;
  logic [fqs_pkg::ROUTES-1:0]  nonempty, ne_post, higher;
  fqs_pkg::find_t              first_f, higher_f, post_f;
  logic                        out_free, in_fire;
  logic                        ram_we, ram_re;
  logic [fqs_pkg::AW-1:0]      ram_addr;
  logic [fqs_pkg::PW-1:0]      ram_rdata;
  logic                        add_ok;
  logic [fqs_pkg::CW-1:0]      add_cnt;
  logic [fqs_pkg::SW-1:0]      n_inc;

  fqs_rate u_rate (
    .rate     (rate_r),
    .interval (interval),
    .size     (size)
  );

  // all queue payloads, route in the upper address bits
  fqs_ram #(
    .WIDTH (fqs_pkg::PW),
    .DEPTH (fqs_pkg::ROUTES * fqs_pkg::QUEUE_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .re    (ram_re),
    .addr  (ram_addr),
    .wdata (in_payload),
    .rdata (ram_rdata)
  );

  // occupancy view used by the route search
  always_comb begin
    for (int i = 0; i < fqs_pkg::ROUTES; i++) begin
      nonempty[i] = cnt_r[i] != '0;
      // after popping from the current route
      ne_post[i]  = nonempty[i] &&
                    !((fqs_pkg::RW'(i) == it_r) && cnt_r[it_r] == fqs_pkg::CW'(1));
      higher[i]   = ne_post[i] && (i > int'(it_r));
    end
  end

  assign first_f  = fqs_pkg::find_first(nonempty);
  assign higher_f = fqs_pkg::find_first(higher);
  assign post_f   = fqs_pkg::find_first(ne_post);

  assign out_free = !out_valid_r || out_ready;
  assign in_ready = (state_r == S_IDLE) && out_free;
  assign in_fire  = in_valid && in_ready;

  assign add_cnt  = cnt_r[in_route];
  assign add_ok   = (hwm_r == '0 || add_cnt < fqs_pkg::CW'(hwm_r))
                    && add_cnt < fqs_pkg::CW'(fqs_pkg::QUEUE_DEPTH);
  assign n_inc    = n_r + fqs_pkg::SW'(1);

  always_comb begin
    state_nxt       = state_r;
    rate_nxt        = rate_r;
    hwm_nxt         = hwm_r;
    head_nxt        = head_r;
    cnt_nxt         = cnt_r;
    resume_nxt      = resume_r;
    resume_v_nxt    = resume_v_r;
    tmr_nxt         = tmr_r;
    it_nxt          = it_r;
    itv_nxt         = itv_r;
    n_nxt           = n_r;
    limit_nxt       = limit_r;
    done_nxt        = done_r;
    dl_route_nxt    = dl_route_r;
    out_valid_nxt   = out_valid_r && !out_ready;
    out_kind_nxt    = out_kind_r;
    out_route_nxt   = out_route_r;
    out_payload_nxt = out_payload_r;
    out_last_nxt    = out_last_r;
    ram_we          = 1'b0;
    ram_re          = 1'b0;
    ram_addr        = {in_route, head_r[in_route] + add_cnt[fqs_pkg::QW-1:0]};

    // configuration must only arrive while idle; the block itself does not enforce this
    if (cfg_we) begin
      unique case (cfg_index)
        fqs_pkg::CFG_RATE: begin
          rate_nxt  = cfg_wdata;
          state_nxt = S_SETUP;
        end
        fqs_pkg::CFG_HWM: hwm_nxt = cfg_wdata[fqs_pkg::HWMW-1:0];
        default: ;
      endcase
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          if (in_cmd == fqs_pkg::CMD_ADD) begin
            // tail write: slot wraps within the route's segment
            out_valid_nxt   = 1'b1;
            out_kind_nxt    = add_ok ? fqs_pkg::KIND_ACCEPT : fqs_pkg::KIND_DROP;
            out_route_nxt   = in_route;
            out_payload_nxt = in_payload;
            out_last_nxt    = 1'b1;
            if (add_ok) begin
              ram_we            = 1'b1;
              cnt_nxt[in_route] = add_cnt + fqs_pkg::CW'(1);
              tmr_nxt = fqs_pkg::timer_setup(tmr_r, rate_r != '0, 1'b1, interval);
            end
          end else if (tmr_r.active) begin
            if (tmr_r.remaining > fqs_pkg::TW'(1)) begin
              tmr_nxt.remaining = tmr_r.remaining - fqs_pkg::TW'(1);
            end else begin
              // timer fired: reload, then start the batch
              tmr_nxt.remaining = tmr_r.first_pass ? '0 : interval;
              if (first_f.found) begin
                tmr_nxt.last_empty = 1'b0;
                it_nxt    = (resume_v_r && nonempty[resume_r]) ? resume_r : first_f.idx;
                limit_nxt = size;
                n_nxt     = '0;
                state_nxt = S_RD;
              end else begin
                tmr_nxt.last_empty = 1'b1;
                state_nxt          = S_FIN;
              end
            end
          end
        end
      end

      S_SETUP: begin
        tmr_nxt   = fqs_pkg::timer_setup(tmr_r, rate_r != '0, |nonempty, interval);
        state_nxt = S_IDLE;
      end

      S_RD: begin
        // pop head of the current route and pick the next route
        ram_re          = 1'b1;
        ram_addr        = {it_r, head_r[it_r]};
        head_nxt[it_r]  = head_r[it_r] + fqs_pkg::QW'(1);
        cnt_nxt[it_r]   = cnt_r[it_r] - fqs_pkg::CW'(1);
        n_nxt           = n_inc;
        dl_route_nxt    = it_r;
        if (cnt_r[it_r] == fqs_pkg::CW'(1)) begin
          // route drained: early stop when nothing lies above it
          resume_nxt   = it_r;
          resume_v_nxt = 1'b1;
          it_nxt       = higher_f.idx;
          itv_nxt      = higher_f.found;
        end else if (higher_f.found) begin
          it_nxt  = higher_f.idx;
          itv_nxt = 1'b1;
        end else begin
          it_nxt  = post_f.idx;
          itv_nxt = post_f.found;
        end
        done_nxt  = (n_inc == limit_r) || !itv_nxt;
        state_nxt = S_OUT;
      end

      S_OUT: begin
        if (out_free) begin
          out_valid_nxt   = 1'b1;
          out_kind_nxt    = fqs_pkg::KIND_DELIVER;
          out_route_nxt   = dl_route_r;
          out_payload_nxt = ram_rdata;
          out_last_nxt    = done_r;
          if (done_r) begin
            if (itv_r) begin
              resume_nxt   = it_r;
              resume_v_nxt = 1'b1;
            end
            state_nxt = S_FIN;
          end else begin
            state_nxt = S_RD;
          end
        end
      end

      S_FIN: begin
        tmr_nxt            = tmr_r;
        tmr_nxt.first_pass = 1'b0;
        tmr_nxt = fqs_pkg::timer_setup(tmr_nxt, rate_r != '0, |nonempty, interval);
        state_nxt = S_IDLE;
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      rate_r      <= '0;
      hwm_r       <= '0;
      resume_r    <= '0;
      resume_v_r  <= 1'b0;
      tmr_r       <= '0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < fqs_pkg::ROUTES; i++) begin
        head_r[i] <= '0;
        cnt_r[i]  <= '0;
      end
    end else begin
      state_r     <= state_nxt;
      rate_r      <= rate_nxt;
      hwm_r       <= hwm_nxt;
      resume_r    <= resume_nxt;
      resume_v_r  <= resume_v_nxt;
      tmr_r       <= tmr_nxt;
      out_valid_r <= out_valid_nxt;
      head_r      <= head_nxt;
      cnt_r       <= cnt_nxt;
    end
  end

  // batch bookkeeping and result payload
  always_ff @(posedge clk) begin
    it_r          <= it_nxt;
    itv_r         <= itv_nxt;
    n_r           <= n_nxt;
    limit_r       <= limit_nxt;
    done_r        <= done_nxt;
    dl_route_r    <= dl_route_nxt;
    out_kind_r    <= out_kind_nxt;
    out_route_r   <= out_route_nxt;
    out_payload_r <= out_payload_nxt;
    out_last_r    <= out_last_nxt;
  end

  assign out_valid   = out_valid_r;
  assign out_kind    = out_kind_r;
  assign out_route   = out_route_r;
  assign out_payload = out_payload_r;
  assign out_last    = out_last_r;

endmodule

// ----- tb/sv/testbench.sv -----
// ----------------------------------------------------------------------------
// testbench
// checks the per-route fair queue shaper: adds, drops and round-robin batches
// against a cycle-free predictor, with random idling on both channels
// ----------------------------------------------------------------------------
module testbench;

  typedef struct packed {
    logic [1:0]             kind;
    logic [fqs_pkg::RW-1:0] route;
    logic [fqs_pkg::PW-1:0] payload;
    logic                   last;
  } result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic in_cmd = fqs_pkg::CMD_ADD;
  logic [fqs_pkg::RW-1:0] in_route = '0;
  logic [fqs_pkg::PW-1:0] in_payload = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [1:0] out_kind;
  logic [fqs_pkg::RW-1:0] out_route;
  logic [fqs_pkg::PW-1:0] out_payload;
  logic out_last;
  logic cfg_we = 1'b0;
  logic cfg_index = fqs_pkg::CFG_RATE;
  logic [fqs_pkg::RATEW-1:0] cfg_wdata = '0;

  per_route_fair_queue_shaper_unit u_dut (.*);

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // predictor state
  logic [fqs_pkg::PW-1:0] store_mem [fqs_pkg::ROUTES][fqs_pkg::QUEUE_DEPTH];
  int unsigned   head_q [fqs_pkg::ROUTES];
  int unsigned   count_q [fqs_pkg::ROUTES];
  int unsigned   resume_r;
  bit            resume_ok;
  bit            tmr_active;
  int unsigned   tmr_left;
  bit            tmr_first;
  bit            batch_was_empty;
  int unsigned   rate_reg;
  int unsigned   hwm_reg;

  result_t expected_results [$];
  int      mismatch_count = 0;
  bit      rx_idle_on = 1'b1;
  bit      tx_idle_on = 1'b1;
  int      rx_hold = 0;

  function automatic int unsigned next_busy(int unsigned from);
    for (int unsigned r = from; r < fqs_pkg::ROUTES; r++) begin
      if (count_q[r] != 0) return r;
    end
    return fqs_pkg::ROUTES;
  endfunction

  function automatic int unsigned interval_ms();
    if (rate_reg == 0) return 0;
    if (rate_reg >= fqs_pkg::FAST_RATE) return fqs_pkg::MIN_INTERVAL_MS;
    return fqs_pkg::MS_PER_SECOND / rate_reg;
  endfunction

  function automatic int unsigned burst_len();
    int unsigned s;
    if (rate_reg == 0) return fqs_pkg::MAX_BURST;
    if (rate_reg < fqs_pkg::FAST_RATE) return 1;
    s = (rate_reg * fqs_pkg::MIN_INTERVAL_MS + 999) / fqs_pkg::MS_PER_SECOND;
    return (s > fqs_pkg::MAX_BURST) ? fqs_pkg::MAX_BURST : s;
  endfunction

  // timer re-evaluation after an accepted add, a batch or a rate write
  function automatic void rearm_timer();
    bit any;
    any = next_busy(0) < fqs_pkg::ROUTES;
    if (rate_reg > 0) begin
      if (any || !batch_was_empty) begin
        if (tmr_active) begin
          if (!tmr_first) tmr_left = interval_ms();
        end else begin
          tmr_first = 1; tmr_active = 1; tmr_left = 0;
        end
      end else begin
        batch_was_empty = 0; tmr_active = 0; tmr_left = 0;
      end
    end else if (any) begin
      if (!tmr_active) begin
        tmr_first = 1; tmr_active = 1;
      end
      tmr_left = 0;
    end else begin
      tmr_active = 0; tmr_left = 0;
    end
  endfunction

  function automatic void drain_batch();
    int unsigned it, lim, n;
    result_t res;
    n = 0;
    it = next_busy(0);
    if (it >= fqs_pkg::ROUTES) begin
      batch_was_empty = 1;
      return;
    end
    batch_was_empty = 0;
    if (resume_ok && count_q[resume_r] != 0) it = resume_r;
    lim = burst_len();
    while (n < lim && it < fqs_pkg::ROUTES) begin
      res.kind = fqs_pkg::KIND_DELIVER;
      res.route = fqs_pkg::RW'(it);
      res.payload = store_mem[it][head_q[it]];
      res.last = 1'b0;
      expected_results.push_back(res);
      head_q[it] = (head_q[it] + 1) % fqs_pkg::QUEUE_DEPTH;
      count_q[it]--;
      n++;
      if (count_q[it] == 0) begin
        resume_r = it; resume_ok = 1;
        it = next_busy(it + 1);
      end else begin
        it = (next_busy(it + 1) < fqs_pkg::ROUTES) ? next_busy(it + 1) : next_busy(0);
      end
    end
    if (it < fqs_pkg::ROUTES) begin
      resume_r = it; resume_ok = 1;
    end
    expected_results[$].last = 1'b1;
  endfunction

  function automatic void predict_request(logic cmd, logic [fqs_pkg::RW-1:0] route,
                                          logic [fqs_pkg::PW-1:0] payload);
    result_t res;
    bit ok;
    int unsigned c;
    if (cmd == fqs_pkg::CMD_ADD) begin
      c = count_q[route];
      ok = !((hwm_reg > 0 && c >= hwm_reg) || c >= fqs_pkg::QUEUE_DEPTH);
      if (ok) begin
        store_mem[route][(head_q[route] + c) % fqs_pkg::QUEUE_DEPTH] = payload;
        count_q[route]++;
        rearm_timer();
      end
      res.kind = ok ? fqs_pkg::KIND_ACCEPT : fqs_pkg::KIND_DROP;
      res.route = route;
      res.payload = payload;
      res.last = 1'b1;
      expected_results.push_back(res);
    end else if (tmr_active) begin
      if (tmr_left > 1) begin
        tmr_left--;
      end else begin
        tmr_left = tmr_first ? 0 : interval_ms();
        drain_batch();
        tmr_first = 0;
        rearm_timer();
      end
    end
  endfunction

  // one request through the input handshake, with optional leading gap;
  // valid stays up after the handshake so requests can follow back to back
  task automatic send_request(logic cmd, logic [fqs_pkg::RW-1:0] route,
                              logic [fqs_pkg::PW-1:0] payload);
    if (tx_idle_on && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_cmd <= cmd;
    in_route <= route;
    in_payload <= payload;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict_request(cmd, route, payload);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  // registers only change with the block idle
  task automatic write_reg(logic idx, int unsigned value);
    wait_drained();
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= fqs_pkg::RATEW'(value);
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == fqs_pkg::CFG_RATE) begin
      rate_reg = value;
      rearm_timer();
    end else begin
      hwm_reg = value & 5'h1f;
    end
  endtask

  task automatic add_item(int unsigned route, logic [fqs_pkg::PW-1:0] payload);
    send_request(fqs_pkg::CMD_ADD, fqs_pkg::RW'(route), payload);
  endtask

  task automatic tick(int n);
    repeat (n) send_request(fqs_pkg::CMD_TICK, fqs_pkg::RW'($urandom), $urandom);
  endtask

  task automatic test_directed();
    write_reg(fqs_pkg::CFG_HWM, 0);
    add_item(0, 32'h0);
    add_item(15, 32'hffff_ffff);
    add_item(15, 32'h5555_aaaa);
    add_item(7, 32'haaaa_5555);
    tick(2);
    // fill one route to physical capacity, then one more is dropped
    for (int i = 0; i < fqs_pkg::QUEUE_DEPTH + 1; i++) add_item(3, $urandom);
    tick(1);
    write_reg(fqs_pkg::CFG_HWM, 16);
    tick(1);
  endtask

  task automatic test_high_water();
    write_reg(fqs_pkg::CFG_HWM, 2);
    for (int i = 0; i < 4; i++) add_item(9, $urandom);
    write_reg(fqs_pkg::CFG_HWM, 1);
    add_item(9, $urandom);
    tick(2);
    write_reg(fqs_pkg::CFG_HWM, 31);
  endtask

  task automatic test_rates();
    int unsigned rates [6] = '{1, 39, 40, 41, 1000, 2560};
    foreach (rates[k]) begin
      write_reg(fqs_pkg::CFG_RATE, rates[k]);
      for (int i = 0; i < 6; i++) add_item($urandom_range(0, 15), $urandom);
      tick(rates[k] == 1 ? 4 : 12);
      if (rates[k] == 2560) tick(20);
    end
    write_reg(fqs_pkg::CFG_RATE, 4095);
    tick(3);
    write_reg(fqs_pkg::CFG_RATE, 0);
    tick(2);
  endtask

  // receiver stalls long while the sender keeps offering adds
  task automatic test_backpressure();
    rx_hold = 300;
    for (int i = 0; i < 20; i++) add_item($urandom_range(0, 15), $urandom);
    wait_drained();
  endtask

  task automatic test_random(int n, int unsigned rate, int tail);
    write_reg(fqs_pkg::CFG_RATE, rate);
    write_reg(fqs_pkg::CFG_HWM, $urandom_range(0, 16));
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 2) == 0) tick(1);
      else add_item($urandom_range(0, $urandom_range(0, 1) ? 3 : 15), $urandom);
    end
    tick(tail);
  endtask

  // checker and receiver idling
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (expected_results.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("unexpected result kind=%0d route=%0d payload=%h last=%0d",
                   out_kind, out_route, out_payload, out_last);
      end else begin
        result_t e;
        e = expected_results.pop_front();
        if (e.kind !== out_kind || e.route !== out_route ||
            e.payload !== out_payload || e.last !== out_last) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display({"mismatch: expected kind=%0d route=%0d payload=%h last=%0d,",
                      " got %0d %0d %h %0d"},
                     e.kind, e.route, e.payload, e.last,
                     out_kind, out_route, out_payload, out_last);
        end
      end
    end
  end

  initial begin : rx_side
    int gap;
    forever begin
      @(posedge clk);
      if (rx_hold > 0) begin
        out_ready <= 1'b0;
        rx_hold--;
      end else if (rx_idle_on && $urandom_range(0, 5) == 0) begin
        gap = $urandom_range(1, 13);
        out_ready <= 1'b0;
        repeat (gap - 1) @(posedge clk);
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  initial begin
    for (int r = 0; r < fqs_pkg::ROUTES; r++) begin
      head_q[r] = 0; count_q[r] = 0;
    end
    resume_r = 0; resume_ok = 0; tmr_active = 0; tmr_left = 0;
    tmr_first = 0; batch_was_empty = 0; rate_reg = 0; hwm_reg = 0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_high_water();
    test_rates();
    test_backpressure();
    test_random(80, 0, 2);
    test_random(60, 60, 30);
    test_random(50, 1000, 30);
    // final stretch with no idling
    rx_idle_on = 1'b0;
    tx_idle_on = 1'b0;
    test_random(40, 0, 2);
    wait_drained();
    repeat (20) @(posedge clk);
    if (mismatch_count == 0 && expected_results.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin
    #30000000;
    $display("Mismatches found");
    $finish;
  end

endmodule
